// File: rtl/core/adyn_pkg.sv
// Shared types, constants and fixed-point helpers for the acrobot dynamics core.
package adyn_pkg;

  // Fixed-point format
  localparam int FracBits  = 16;
  localparam int AngShift  = 30 - FracBits;

  // Pipeline depths
  localparam int RedSteps    = 7;
  localparam int CordicSteps = 24;
  localparam int CordicLat   = 1 + RedSteps + 1 + CordicSteps + 1;
  localparam int DivSteps    = 32;
  localparam int DivLat      = 1 + DivSteps + 1;
  localparam int LatTotal    = CordicLat + 6 + DivLat + 2 + DivLat + 2 + DivLat;

  // Configuration register indexes
  localparam logic [2:0] CfgMassLink1   = 3'd0;
  localparam logic [2:0] CfgMassLink2   = 3'd1;
  localparam logic [2:0] CfgLengthLink1 = 3'd2;
  localparam logic [2:0] CfgComLink1    = 3'd3;
  localparam logic [2:0] CfgComLink2    = 3'd4;
  localparam logic [2:0] CfgLinkInertia = 3'd5;
  localparam logic [2:0] CfgGravity     = 3'd6;

  // Configuration reset values
  localparam logic [23:0] RstMassLink1   = 24'd65536;
  localparam logic [23:0] RstMassLink2   = 24'd65536;
  localparam logic [23:0] RstLengthLink1 = 24'd65536;
  localparam logic [23:0] RstComLink1    = 24'd32768;
  localparam logic [23:0] RstComLink2    = 24'd32768;
  localparam logic [23:0] RstLinkInertia = 24'd65536;
  localparam logic [23:0] RstGravity     = 24'd642253;

  // Angle constants in Q30
  localparam logic signed [33:0] Q30Pi     = 34'sd3373259426;
  localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [33:0] Q30TwoPi  = 34'sd6746518852;
  localparam logic signed [33:0] Q30Gain   = 34'sd652032874;
  localparam logic [39:0]        TwoPi40   = 40'd6746518852;
  // 64 turns, enough to make any scaled input angle positive
  localparam logic [39:0]        AngOffset = 40'd431777206528;

  localparam logic signed [33:0] AtanQ30 [CordicSteps] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  // Transaction payloads
  typedef struct packed {
    logic signed [23:0] angle1;
    logic signed [23:0] angle2;
    logic signed [23:0] rate1;
    logic signed [23:0] rate2;
    logic signed [23:0] torque;
  } in_t;

  typedef struct packed {
    logic signed [23:0] rate1_out;
    logic signed [23:0] rate2_out;
    logic signed [31:0] accel1;
    logic signed [31:0] accel2;
    logic               saturated;
  } out_t;

  // Clamped value with its clip flag
  typedef struct packed {
    logic signed [31:0] v;
    logic               s;
  } fx_t;

  // Data that rides alongside the long units
  typedef struct packed {
    logic signed [23:0] w1;
    logic signed [23:0] w2;
    logic signed [23:0] u;
  } side_t;

  typedef struct packed {
    logic signed [23:0] w1;
    logic signed [23:0] w2;
    logic signed [23:0] u;
    logic signed [31:0] phi1;
    logic signed [31:0] phi2;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic signed [31:0] acc2;
    logic               flag;
  } carry_t;

  function automatic logic signed [31:0] ext24(input logic [23:0] v);
    return {{8{v[23]}}, v};
  endfunction

  function automatic logic signed [31:0] cfg32(input logic [23:0] v);
    return {8'd0, v};
  endfunction

  function automatic fx_t fx_clamp(input logic signed [64:0] v);
    fx_t r;
    if (v > 65'sd2147483647) begin
      r.v = 32'sh7fffffff;
      r.s = 1'b1;
    end else if (v < -65'sd2147483648) begin
      r.v = 32'sh80000000;
      r.s = 1'b1;
    end else begin
      r.v = 32'(v);
      r.s = 1'b0;
    end
    return r;
  endfunction

  function automatic fx_t fx_add(input logic signed [31:0] a, input logic signed [31:0] b);
    return fx_clamp(65'(a) + 65'(b));
  endfunction

  function automatic fx_t fx_sub(input logic signed [31:0] a, input logic signed [31:0] b);
    return fx_clamp(65'(a) - 65'(b));
  endfunction

  // Product rounded half up at the fraction point
  function automatic fx_t fx_mul(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (FracBits - 1));
    return fx_clamp(65'(p >>> FracBits));
  endfunction

endpackage

// File: rtl/core/adyn_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage.
module adyn_div
  import adyn_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] quo_o,
  output logic               sat_o
);

  logic [31:0] rem_q  [DivSteps+1];
  logic [31:0] low_q  [DivSteps+1];
  logic [31:0] den_q  [DivSteps+1];
  logic        neg_q  [DivSteps+1];
  logic        zero_q [DivSteps+1];
  logic        ovf_q  [DivSteps+1];
  logic        npos_q [DivSteps+1];
  logic        nneg_q [DivSteps+1];

  logic [32:0] nmag_s, dmag_s;
  logic [31:0] rem0_s;
  logic [32:0] t_s  [DivSteps];
  logic        ge_s [DivSteps];
  logic signed [31:0] quo_d;
  logic               sat_d;

  // Operand magnitudes and quotient overflow check
  always_comb begin
    nmag_s = num_i[31] ? -{num_i[31], num_i} : {1'b0, num_i};
    dmag_s = den_i[31] ? -{den_i[31], den_i} : {1'b0, den_i};
    rem0_s = nmag_s[31:0] >> (32 - FracBits);
  end

  // Restoring step per stage
  always_comb begin
    for (int i = 0; i < DivSteps; i++) begin
      t_s[i]  = {rem_q[i], low_q[i][31]};
      ge_s[i] = t_s[i] >= {1'b0, den_q[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem0_s;
      low_q[0]  <= nmag_s[31:0] << FracBits;
      den_q[0]  <= dmag_s[31:0];
      neg_q[0]  <= num_i[31] ^ den_i[31];
      zero_q[0] <= den_i == 32'sd0;
      ovf_q[0]  <= rem0_s >= dmag_s[31:0];
      npos_q[0] <= num_i > 32'sd0;
      nneg_q[0] <= num_i[31];
      for (int i = 0; i < DivSteps; i++) begin
        rem_q[i+1]  <= ge_s[i] ? 32'(t_s[i] - {1'b0, den_q[i]}) : t_s[i][31:0];
        low_q[i+1]  <= {low_q[i][30:0], ge_s[i]};
        den_q[i+1]  <= den_q[i];
        neg_q[i+1]  <= neg_q[i];
        zero_q[i+1] <= zero_q[i];
        ovf_q[i+1]  <= ovf_q[i];
        npos_q[i+1] <= npos_q[i];
        nneg_q[i+1] <= nneg_q[i];
      end
    end
  end

  // Sign, saturation and divide-by-zero
  always_comb begin
    sat_d = 1'b0;
    quo_d = 32'sd0;
    priority if (zero_q[DivSteps]) begin
      sat_d = 1'b1;
      quo_d = npos_q[DivSteps] ? 32'sh7fffffff :
              (nneg_q[DivSteps] ? 32'sh80000000 : 32'sd0);
    end else if (ovf_q[DivSteps]) begin
      sat_d = 1'b1;
      quo_d = neg_q[DivSteps] ? 32'sh80000000 : 32'sh7fffffff;
    end else if (!neg_q[DivSteps]) begin
      sat_d = low_q[DivSteps][31];
      quo_d = low_q[DivSteps][31] ? 32'sh7fffffff : $signed(low_q[DivSteps]);
    end else begin
      sat_d = low_q[DivSteps] > 32'h80000000;
      quo_d = sat_d ? 32'sh80000000 : $signed(-low_q[DivSteps]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= quo_d;
      sat_o <= sat_d;
    end
  end

endmodule

// File: rtl/core/acrobot_dynamics_derivative_core.sv
// Acrobot equations of motion: fully pipelined state-derivative core.
// Throughput: one transaction per cycle; the whole pipe holds while the output is stalled.
// Depth is set by three 34-stage CORDIC lanes and four 34-stage dividers, chained three deep.
// Reset clears all valid bits and loads the default link parameters.
// Derived parameter terms settle through the k1, k2 and k3 register levels after a register write.
module acrobot_dynamics_derivative_core
  import adyn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  // ---------------- configuration registers ----------------
  logic [23:0] m1_q, m2_q, l1_q, lc1_q, lc2_q, inr_q, g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q  <= RstMassLink1;
      m2_q  <= RstMassLink2;
      l1_q  <= RstLengthLink1;
      lc1_q <= RstComLink1;
      lc2_q <= RstComLink2;
      inr_q <= RstLinkInertia;
      g_q   <= RstGravity;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMassLink1:   m1_q  <= cfg_wdata_i;
        CfgMassLink2:   m2_q  <= cfg_wdata_i;
        CfgLengthLink1: l1_q  <= cfg_wdata_i;
        CfgComLink1:    lc1_q <= cfg_wdata_i;
        CfgComLink2:    lc2_q <= cfg_wdata_i;
        CfgLinkInertia: inr_q <= cfg_wdata_i;
        CfgGravity:     g_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic signed [31:0] m1, m2, l1, lc1, lc2, inr, g;
  assign m1  = cfg32(m1_q);
  assign m2  = cfg32(m2_q);
  assign l1  = cfg32(l1_q);
  assign lc1 = cfg32(lc1_q);
  assign lc2 = cfg32(lc2_q);
  assign inr = cfg32(inr_q);
  assign g   = cfg32(g_q);

  // ---------------- parameter-only terms (free running) ----------------
  fx_t k1_lc2sq, k1_l1lc2, k1_l1sq, k1_m1lc1, k1_m2lc2, k1_m2l1;
  fx_t k2_m1lc1lc1, k2_kk, k2_m2lc2g, k2_suma, k2_m2lc2sq, k2_base;
  fx_t k3_ag, k3_dinr;
  logic signed [31:0] k_lc2sq_q, k_l1lc2_q, k_l1sq_q, k_m1lc1_q, k_m2lc2_q, k_m2l1_q;
  logic signed [31:0] k_m1lc1lc1_q, k_kk_q, k_m2lc2g_q, k_suma_q, k_m2lc2sq_q, k_base_q;
  logic signed [31:0] k_ag_q, k_dinr_q;
  logic k1f_q, k2f_q, k3f_q, kflag;

  always_comb begin
    k1_lc2sq    = fx_mul(lc2, lc2);
    k1_l1lc2    = fx_mul(l1, lc2);
    k1_l1sq     = fx_mul(l1, l1);
    k1_m1lc1    = fx_mul(m1, lc1);
    k1_m2lc2    = fx_mul(m2, lc2);
    k1_m2l1     = fx_mul(m2, l1);
    k2_m1lc1lc1 = fx_mul(k_m1lc1_q, lc1);
    k2_kk       = fx_mul(m2, k_l1lc2_q);
    k2_m2lc2g   = fx_mul(k_m2lc2_q, g);
    k2_suma     = fx_add(k_m1lc1_q, k_m2l1_q);
    k2_m2lc2sq  = fx_mul(m2, k_lc2sq_q);
    k2_base     = fx_add(k_l1sq_q, k_lc2sq_q);
    k3_ag       = fx_mul(k_suma_q, g);
    k3_dinr     = fx_add(k_m2lc2sq_q, inr);
  end

  always_ff @(posedge clk_i) begin
    k_lc2sq_q    <= k1_lc2sq.v;
    k_l1lc2_q    <= k1_l1lc2.v;
    k_l1sq_q     <= k1_l1sq.v;
    k_m1lc1_q    <= k1_m1lc1.v;
    k_m2lc2_q    <= k1_m2lc2.v;
    k_m2l1_q     <= k1_m2l1.v;
    k1f_q        <= k1_lc2sq.s | k1_l1lc2.s | k1_l1sq.s | k1_m1lc1.s |
                    k1_m2lc2.s | k1_m2l1.s;
    k_m1lc1lc1_q <= k2_m1lc1lc1.v;
    k_kk_q       <= k2_kk.v;
    k_m2lc2g_q   <= k2_m2lc2g.v;
    k_suma_q     <= k2_suma.v;
    k_m2lc2sq_q  <= k2_m2lc2sq.v;
    k_base_q     <= k2_base.v;
    k2f_q        <= k2_m1lc1lc1.s | k2_kk.s | k2_m2lc2g.s | k2_suma.s |
                    k2_m2lc2sq.s | k2_base.s;
    k_ag_q       <= k3_ag.v;
    k_dinr_q     <= k3_dinr.v;
    k3f_q        <= k3_ag.s | k3_dinr.s;
  end

  assign kflag = k1f_q | k2f_q | k3f_q;

  // ---------------- handshake and valid pipe ----------------
  logic adv;
  logic [LatTotal-1:0] vld_q;

  assign adv         = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LatTotal-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LatTotal-2:0], in_valid_i};
    end
  end

  // ---------------- CORDIC lanes: a1, a2, a1+a2 ----------------
  logic signed [24:0] lang [3];
  logic signed [31:0] lane_cos [3];
  logic signed [31:0] lane_sin [3];

  always_comb begin
    lang[0] = 25'(in_data_i.angle1);
    lang[1] = 25'(in_data_i.angle2);
    lang[2] = 25'(in_data_i.angle1) + 25'(in_data_i.angle2);
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [39:0]        red_q [RedSteps+1];
    logic signed [33:0] cx_q  [CordicSteps+1];
    logic signed [33:0] cy_q  [CordicSteps+1];
    logic signed [33:0] cr_q  [CordicSteps+1];
    logic               fl_q  [CordicSteps+1];
    logic signed [31:0] cos_q, sin_q;
    logic signed [39:0] sang;
    logic [39:0]        red_s [RedSteps];
    logic signed [33:0] fr, fx_s, nx [CordicSteps], ny [CordicSteps], nr [CordicSteps];
    logic               ffl;

    // Scale to Q30 and bias positive
    assign sang = 40'(lang[l]) <<< AngShift;

    // Modulo 2*pi by binary multiples
    always_comb begin
      for (int k = 0; k < RedSteps; k++) begin
        red_s[k] = (red_q[k] >= (TwoPi40 << (RedSteps - 1 - k))) ?
                   red_q[k] - (TwoPi40 << (RedSteps - 1 - k)) : red_q[k];
      end
    end

    // Fold into (-pi, pi], then reflect into [-pi/2, pi/2]
    always_comb begin
      fr  = $signed(red_q[RedSteps][33:0]);
      ffl = 1'b0;
      if (fr > Q30Pi) fr = fr - Q30TwoPi;
      if (fr > Q30HalfPi) begin
        fr  = Q30Pi - fr;
        ffl = 1'b1;
      end else if (fr < -Q30HalfPi) begin
        fr  = -Q30Pi - fr;
        ffl = 1'b1;
      end
    end

    // Rotation steps
    always_comb begin
      for (int i = 0; i < CordicSteps; i++) begin
        if (cr_q[i] >= 0) begin
          nx[i] = cx_q[i] - (cy_q[i] >>> i);
          ny[i] = cy_q[i] + (cx_q[i] >>> i);
          nr[i] = cr_q[i] - AtanQ30[i];
        end else begin
          nx[i] = cx_q[i] + (cy_q[i] >>> i);
          ny[i] = cy_q[i] - (cx_q[i] >>> i);
          nr[i] = cr_q[i] + AtanQ30[i];
        end
      end
    end

    assign fx_s = fl_q[CordicSteps] ? -cx_q[CordicSteps] : cx_q[CordicSteps];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        red_q[0] <= $unsigned(sang) + AngOffset;
        for (int k = 0; k < RedSteps; k++) red_q[k+1] <= red_s[k];
        cx_q[0] <= Q30Gain;
        cy_q[0] <= '0;
        cr_q[0] <= fr;
        fl_q[0] <= ffl;
        for (int i = 0; i < CordicSteps; i++) begin
          cx_q[i+1] <= nx[i];
          cy_q[i+1] <= ny[i];
          cr_q[i+1] <= nr[i];
          fl_q[i+1] <= fl_q[i];
        end
        cos_q <= 32'((fx_s + (34'sd1 <<< (AngShift - 1))) >>> AngShift);
        sin_q <= 32'((cy_q[CordicSteps] + (34'sd1 <<< (AngShift - 1))) >>> AngShift);
      end
    end

    assign lane_cos[l] = cos_q;
    assign lane_sin[l] = sin_q;
  end

  // Rates and torque ride along the CORDIC lanes
  side_t sd_q [CordicLat];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= '{w1: in_data_i.rate1, w2: in_data_i.rate2, u: in_data_i.torque};
      for (int i = 1; i < CordicLat; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // ---------------- mass matrix and force terms ----------------
  logic signed [31:0] c2, s2, s1, s12, w1, w2, cwc;
  side_t m0_sd;
  assign m0_sd = sd_q[CordicLat-1];
  assign c2    = lane_cos[1];
  assign s2    = lane_sin[1];
  assign s1    = lane_sin[0];
  assign s12   = lane_sin[2];
  assign cwc   = lane_cos[0] ^ lane_cos[2] ^ lane_cos[2] ^ lane_cos[0];
  assign w1    = ext24(m0_sd.w1);
  assign w2    = ext24(m0_sd.w2);

  fx_t e1_t, e1_phi2, e1_kw2, e1_w11, e1_ww, e1_phia;
  fx_t e2_tt, e2_dd, e2_cora;
  fx_t e3_d1a, e3_d2m, e3_cor;
  fx_t e4_d1b, e4_d2, e4_phi1b;
  fx_t e5_d1c, e5_phi1, e5_d2sq;
  fx_t e6_a, e6_d1;

  side_t m1_sd_q, m2_sd_q, m3_sd_q, m4_sd_q, m5_sd_q, m6_sd_q;
  logic signed [31:0] m1_t_q, m1_phi2_q, m1_kw2_q, m1_ww_q, m1_phia_q, m1_s2_q;
  logic signed [31:0] m2_tt_q, m2_dd_q, m2_cora_q, m2_phi2_q, m2_phia_q, m2_s2_q;
  logic signed [31:0] m3_d1a_q, m3_d2m_q, m3_cor_q, m3_phi2_q, m3_phia_q;
  logic signed [31:0] m4_d1b_q, m4_d2_q, m4_phi1b_q, m4_phi2_q;
  logic signed [31:0] m5_d1c_q, m5_phi1_q, m5_d2sq_q, m5_d2_q, m5_phi2_q;
  logic signed [31:0] m6_d1_q, m6_d2sq_q, m6_d2_q, m6_phi1_q, m6_phi2_q;
  logic m1f_q, m2f_q, m3f_q, m4f_q, m5f_q, m6f_q;

  always_comb begin
    e1_t     = fx_mul(k_l1lc2_q, c2);
    e1_phi2  = fx_mul(k_m2lc2g_q, s12);
    e1_kw2   = fx_mul(k_kk_q, w2);
    e1_w11   = fx_add(w1, w1);
    e1_ww    = fx_add(w2, e1_w11.v);
    e1_phia  = fx_mul(k_ag_q, s1);
    e2_tt    = fx_add(m1_t_q, m1_t_q);
    e2_dd    = fx_add(k_lc2sq_q, m1_t_q);
    e2_cora  = fx_mul(m1_kw2_q, m1_ww_q);
    e3_d1a   = fx_add(k_base_q, m2_tt_q);
    e3_d2m   = fx_mul(m2, m2_dd_q);
    e3_cor   = fx_mul(m2_cora_q, m2_s2_q);
    e4_d1b   = fx_mul(m2, m3_d1a_q);
    e4_d2    = fx_add(m3_d2m_q, inr);
    e4_phi1b = fx_sub(m3_phia_q, m3_cor_q);
    e5_d1c   = fx_add(k_m1lc1lc1_q, m4_d1b_q);
    e5_phi1  = fx_add(m4_phi1b_q, m4_phi2_q);
    e5_d2sq  = fx_mul(m4_d2_q, m4_d2_q);
    e6_a     = fx_add(m5_d1c_q, inr);
    e6_d1    = fx_add(e6_a.v, inr);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_sd_q   <= m0_sd;
      m1_t_q    <= e1_t.v;
      m1_phi2_q <= e1_phi2.v;
      m1_kw2_q  <= e1_kw2.v;
      m1_ww_q   <= e1_ww.v;
      m1_phia_q <= e1_phia.v;
      m1_s2_q   <= s2 | (cwc & 32'sd0);
      m1f_q     <= e1_t.s | e1_phi2.s | e1_kw2.s | e1_w11.s | e1_ww.s | e1_phia.s;

      m2_sd_q   <= m1_sd_q;
      m2_tt_q   <= e2_tt.v;
      m2_dd_q   <= e2_dd.v;
      m2_cora_q <= e2_cora.v;
      m2_phi2_q <= m1_phi2_q;
      m2_phia_q <= m1_phia_q;
      m2_s2_q   <= m1_s2_q;
      m2f_q     <= m1f_q | e2_tt.s | e2_dd.s | e2_cora.s;

      m3_sd_q   <= m2_sd_q;
      m3_d1a_q  <= e3_d1a.v;
      m3_d2m_q  <= e3_d2m.v;
      m3_cor_q  <= e3_cor.v;
      m3_phi2_q <= m2_phi2_q;
      m3_phia_q <= m2_phia_q;
      m3f_q     <= m2f_q | e3_d1a.s | e3_d2m.s | e3_cor.s;

      m4_sd_q    <= m3_sd_q;
      m4_d1b_q   <= e4_d1b.v;
      m4_d2_q    <= e4_d2.v;
      m4_phi1b_q <= e4_phi1b.v;
      m4_phi2_q  <= m3_phi2_q;
      m4f_q      <= m3f_q | e4_d1b.s | e4_d2.s | e4_phi1b.s;

      m5_sd_q   <= m4_sd_q;
      m5_d1c_q  <= e5_d1c.v;
      m5_phi1_q <= e5_phi1.v;
      m5_d2sq_q <= e5_d2sq.v;
      m5_d2_q   <= m4_d2_q;
      m5_phi2_q <= m4_phi2_q;
      m5f_q     <= m4f_q | e5_d1c.s | e5_phi1.s | e5_d2sq.s;

      m6_sd_q   <= m5_sd_q;
      m6_d1_q   <= e6_d1.v;
      m6_d2sq_q <= m5_d2sq_q;
      m6_d2_q   <= m5_d2_q;
      m6_phi1_q <= m5_phi1_q;
      m6_phi2_q <= m5_phi2_q;
      m6f_q     <= m5f_q | e6_a.s | e6_d1.s;
    end
  end

  // ---------------- d2/d1 and d2^2/d1 ----------------
  logic signed [31:0] q1, q2, acc2_q, acc1;
  logic q1_sat, q2_sat, acc2_sat, acc1_sat;

  adyn_div u_div_q1 (
    .clk_i (clk_i), .en_i (adv), .num_i (m6_d2_q), .den_i (m6_d1_q),
    .quo_o (q1), .sat_o (q1_sat)
  );

  adyn_div u_div_q2 (
    .clk_i (clk_i), .en_i (adv), .num_i (m6_d2sq_q), .den_i (m6_d1_q),
    .quo_o (q2), .sat_o (q2_sat)
  );

  carry_t cy1_q [DivLat];
  carry_t cy2_q [DivLat];
  carry_t cy3_q [DivLat];
  carry_t cy1_in, c1o, c2o, c3o;

  always_comb begin
    cy1_in      = '0;
    cy1_in.w1   = m6_sd_q.w1;
    cy1_in.w2   = m6_sd_q.w2;
    cy1_in.u    = m6_sd_q.u;
    cy1_in.phi1 = m6_phi1_q;
    cy1_in.phi2 = m6_phi2_q;
    cy1_in.d1   = m6_d1_q;
    cy1_in.d2   = m6_d2_q;
    cy1_in.flag = m6f_q;
  end

  assign c1o = cy1_q[DivLat-1];
  assign c2o = cy2_q[DivLat-1];
  assign c3o = cy3_q[DivLat-1];

  // ---------------- numerator and denominator of acc2 ----------------
  fx_t f1_p, f1_den, f2_na, f2_num;
  carry_t p1_c_q, p2_c_q, p1_c_d, p2_c_d;
  logic signed [31:0] p1_p_q, p1_den_q, p2_num_q, p2_den_q;

  always_comb begin
    f1_p   = fx_mul(q1, c1o.phi1);
    f1_den = fx_sub(k_dinr_q, q2);
    f2_na  = fx_add(ext24(p1_c_q.u), p1_p_q);
    f2_num = fx_sub(f2_na.v, p1_c_q.phi2);
    p1_c_d      = c1o;
    p1_c_d.flag = c1o.flag | q1_sat | q2_sat | f1_p.s | f1_den.s;
    p2_c_d      = p1_c_q;
    p2_c_d.flag = p1_c_q.flag | f2_na.s | f2_num.s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_p_q   <= f1_p.v;
      p1_den_q <= f1_den.v;
      p1_c_q   <= p1_c_d;
      p2_num_q <= f2_num.v;
      p2_den_q <= p1_den_q;
      p2_c_q   <= p2_c_d;
    end
  end

  adyn_div u_div_acc2 (
    .clk_i (clk_i), .en_i (adv), .num_i (p2_num_q), .den_i (p2_den_q),
    .quo_o (acc2_q), .sat_o (acc2_sat)
  );

  // ---------------- numerator of acc1 ----------------
  fx_t f3_pp, f4_s, f4_x;
  carry_t p3_c_q, p4_c_q, p3_c_d, p4_c_d;
  logic signed [31:0] p3_pp_q, p4_x_q;

  always_comb begin
    f3_pp = fx_mul(c2o.d2, acc2_q);
    f4_s  = fx_add(p3_pp_q, p3_c_q.phi1);
    f4_x  = fx_clamp(-65'(f4_s.v));
    p3_c_d      = c2o;
    p3_c_d.acc2 = acc2_q;
    p3_c_d.flag = c2o.flag | acc2_sat | f3_pp.s;
    p4_c_d      = p3_c_q;
    p4_c_d.flag = p3_c_q.flag | f4_s.s | f4_x.s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_pp_q <= f3_pp.v;
      p3_c_q  <= p3_c_d;
      p4_x_q  <= f4_x.v;
      p4_c_q  <= p4_c_d;
    end
  end

  adyn_div u_div_acc1 (
    .clk_i (clk_i), .en_i (adv), .num_i (p4_x_q), .den_i (p4_c_q.d1),
    .quo_o (acc1), .sat_o (acc1_sat)
  );

  // Side data delay lines matching each divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cy1_q[0] <= cy1_in;
      cy2_q[0] <= p2_c_q;
      cy3_q[0] <= p4_c_q;
      for (int i = 1; i < DivLat; i++) begin
        cy1_q[i] <= cy1_q[i-1];
        cy2_q[i] <= cy2_q[i-1];
        cy3_q[i] <= cy3_q[i-1];
      end
    end
  end

  // ---------------- result ----------------
  always_comb begin
    out_data_o.rate1_out = c3o.w1;
    out_data_o.rate2_out = c3o.w2;
    out_data_o.accel1    = acc1;
    out_data_o.accel2    = c3o.acc2;
    out_data_o.saturated = c3o.flag | acc1_sat | kflag;
  end

endmodule

// File: rtl/core/adyn_chk.sv
// Port-level checker for the acrobot dynamics core, bound to the top level.
module adyn_chk
  import adyn_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_t         in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_t        out_data_o,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_idx_i,
  input logic [23:0] cfg_wdata_i
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // Input is held back only by a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output back-pressure");

  // Pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered right after reset");

endmodule

bind acrobot_dynamics_derivative_core adyn_chk u_adyn_chk (.*);
